// File: design/ctpc_pkg.sv
// ----------------------------------------------------------------------------
// ctpc_pkg - shared definitions for the three-point collinearity classifier
// Default coordinate width, register width, verdict codes and the stage
// advance group that the pipeline control hands to the cross-product unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ctpc_pkg;

  // default coordinate width in bits (two's complement)
  localparam int COORD_BITS_DEF = 12;

  // tolerance register width
  localparam int TOL_BITS = 53;

  // verdict word width
  localparam int VERDICT_BITS = 3;

  // verdict codes
  typedef enum logic [VERDICT_BITS-1:0] {
    VERDICT_NOT_COLLINEAR = 3'd0,
    VERDICT_A_BETWEEN     = 3'd1,
    VERDICT_B_BETWEEN     = 3'd2,
    VERDICT_C_BETWEEN     = 3'd3,
    VERDICT_NONE_BETWEEN  = 3'd4
  } verdict_t;

  // per-stage load enables, stage 1 is the input side
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } ctpc_adv_t;

endpackage

`default_nettype wire

// File: design/ctpc_cross_mag.sv
// ----------------------------------------------------------------------------
// ctpc_cross_mag - squared magnitude of a cross product
// Pipeline stages 2 to 5: component products, cross terms, squares, sum.
// Each stage loads when its advance bit from the top level is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ctpc_cross_mag
  import ctpc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  ctpc_adv_t                    adv,
  input  logic signed [COORD_BITS:0]   u [3],
  input  logic signed [COORD_BITS:0]   v [3],
  output logic [4*COORD_BITS+3:0]      mag
);

  localparam int DW   = COORD_BITS + 1;      // difference width
  localparam int PW   = 2 * DW;              // product width
  localparam int KW   = PW + 1;              // cross term width
  localparam int MW   = 4 * COORD_BITS + 2;  // square of a cross term
  localparam int MAGW = 4 * COORD_BITS + 4;  // sum of three squares

  // stage 2 registers: six component products
  logic signed [PW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  // stage 3 registers: cross product
  logic signed [KW-1:0] k [3];
  // stage 4 registers: squares
  logic [MW-1:0]        k_sq [3];

  logic signed [2*KW-1:0] k_sq_full [3];

  // stage 2: products
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      p_yz <= PW'(u[1]) * PW'(v[2]);
      p_zy <= PW'(u[2]) * PW'(v[1]);
      p_zx <= PW'(u[2]) * PW'(v[0]);
      p_xz <= PW'(u[0]) * PW'(v[2]);
      p_xy <= PW'(u[0]) * PW'(v[1]);
      p_yx <= PW'(u[1]) * PW'(v[0]);
    end
  end

  // stage 3: cross terms
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      k[0] <= KW'(p_yz) - KW'(p_zy);
      k[1] <= KW'(p_zx) - KW'(p_xz);
      k[2] <= KW'(p_xy) - KW'(p_yx);
    end
  end

  // squares, nonnegative and below 2^MW
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k_sq_full[i] = (2*KW)'(k[i]) * (2*KW)'(k[i]);
    end
  end

  // stage 4: register squares
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      for (int i = 0; i < 3; i++) begin
        k_sq[i] <= k_sq_full[i][MW-1:0];
      end
    end
  end

  // stage 5: sum of squares
  always_ff @(posedge clk) begin
    if (adv.s5) begin
      mag <= MAGW'(k_sq[0]) + MAGW'(k_sq[1]) + MAGW'(k_sq[2]);
    end
  end

endmodule

`default_nettype wire

// File: design/collinear_three_point_classify.sv
// ----------------------------------------------------------------------------
// collinear_three_point_classify - collinearity test for three 3D points
// Usage:
//   Input channel (in_valid/in_ready) carries one word: points a, b, c as
//   signed COORD_BITS-bit coordinates. Output channel (out_valid/out_ready)
//   returns one verdict word per input word, in order: 0 not collinear,
//   1 a between, 2 b between, 3 c between, 4 none between. Points are not
//   collinear when |(b-a) x (c-a)|^2 exceeds the tolerance register.
//   User writes cfg_we/cfg_wdata only while the block is idle (not enforced).
// Timing:
//   Six register stages; the verdict is registered in stage 6, behind
//   stages 1 to 5. One word per cycle sustained while out_ready stays
//   high, with one multiplier per product in stages 2 and 4.
// Reset and stall:
//   rst clears all stage valid bits and the tolerance (to 0). When the
//   receiver holds out_ready low the last stage keeps its verdict and
//   earlier stages keep filling bubbles; in_ready drops once every stage
//   holds a word.
// ----------------------------------------------------------------------------
`default_nettype none

module collinear_three_point_classify
  import ctpc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [TOL_BITS-1:0]           cfg_wdata,
  // input word
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  ax,
  input  logic signed [COORD_BITS-1:0]  ay,
  input  logic signed [COORD_BITS-1:0]  az,
  input  logic signed [COORD_BITS-1:0]  bx,
  input  logic signed [COORD_BITS-1:0]  by_coord,
  input  logic signed [COORD_BITS-1:0]  bz,
  input  logic signed [COORD_BITS-1:0]  cx,
  input  logic signed [COORD_BITS-1:0]  cy,
  input  logic signed [COORD_BITS-1:0]  cz,
  // output word
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [VERDICT_BITS-1:0]       verdict
);

  localparam int DW   = COORD_BITS + 1;      // difference width
  localparam int SQW  = 2 * COORD_BITS;      // square of a difference
  localparam int DSW  = 2 * COORD_BITS + 2;  // squared distance
  localparam int MAGW = 4 * COORD_BITS + 4;  // squared cross magnitude

  // tolerance register
  logic [TOL_BITS-1:0] tolerance;

  // stage valid bits and advance enables
  logic [6:1] vld;
  ctpc_adv_t  adv;

  // stage 1: u = b-a, v = c-a, w = c-b
  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] v [3];
  logic signed [DW-1:0] w [3];
  // stage 2: squared components
  logic [SQW-1:0] u_sq [3];
  logic [SQW-1:0] v_sq [3];
  logic [SQW-1:0] w_sq [3];
  // stage 3 and 4: squared distances
  logic [DSW-1:0] d_ab, d_ac, d_bc;
  logic [DSW-1:0] d_ab4, d_ac4, d_bc4;
  // stage 5: between flags
  logic a_btw, b_btw, c_btw;
  // cross magnitude at stage 5
  logic [MAGW-1:0] mag;
  // stage 6: verdict
  verdict_t verdict_r;
  verdict_t verdict_next;

  logic signed [2*DW-1:0] u_sq_full [3];
  logic signed [2*DW-1:0] v_sq_full [3];
  logic signed [2*DW-1:0] w_sq_full [3];

  // pipeline control: a stage loads when empty or when the next one loads
  always_comb begin
    adv.s6 = !vld[6] || out_ready;
    adv.s5 = !vld[5] || adv.s6;
    adv.s4 = !vld[4] || adv.s5;
    adv.s3 = !vld[3] || adv.s4;
    adv.s2 = !vld[2] || adv.s3;
    adv.s1 = !vld[1] || adv.s2;
  end

  assign in_ready  = adv.s1;
  assign out_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv.s1) vld[1] <= in_valid;
      if (adv.s2) vld[2] <= vld[1];
      if (adv.s3) vld[3] <= vld[2];
      if (adv.s4) vld[4] <= vld[3];
      if (adv.s5) vld[5] <= vld[4];
      if (adv.s6) vld[6] <= vld[5];
    end
  end

  // tolerance write
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= '0;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  // stage 1: edge vectors
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      u[0] <= DW'(bx) - DW'(ax);
      u[1] <= DW'(by_coord) - DW'(ay);
      u[2] <= DW'(bz) - DW'(az);
      v[0] <= DW'(cx) - DW'(ax);
      v[1] <= DW'(cy) - DW'(ay);
      v[2] <= DW'(cz) - DW'(az);
      w[0] <= DW'(cx) - DW'(bx);
      w[1] <= DW'(cy) - DW'(by_coord);
      w[2] <= DW'(cz) - DW'(bz);
    end
  end

  // component squares, each below 2^SQW
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_sq_full[i] = (2*DW)'(u[i]) * (2*DW)'(u[i]);
      v_sq_full[i] = (2*DW)'(v[i]) * (2*DW)'(v[i]);
      w_sq_full[i] = (2*DW)'(w[i]) * (2*DW)'(w[i]);
    end
  end

  // stage 2: register squares
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      for (int i = 0; i < 3; i++) begin
        u_sq[i] <= u_sq_full[i][SQW-1:0];
        v_sq[i] <= v_sq_full[i][SQW-1:0];
        w_sq[i] <= w_sq_full[i][SQW-1:0];
      end
    end
  end

  // stage 3: squared distances
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      d_ab <= DSW'(u_sq[0]) + DSW'(u_sq[1]) + DSW'(u_sq[2]);
      d_ac <= DSW'(v_sq[0]) + DSW'(v_sq[1]) + DSW'(v_sq[2]);
      d_bc <= DSW'(w_sq[0]) + DSW'(w_sq[1]) + DSW'(w_sq[2]);
    end
  end

  // stage 4: carry distances alongside the cross squares
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      d_ab4 <= d_ab;
      d_ac4 <= d_ac;
      d_bc4 <= d_bc;
    end
  end

  // stage 5: strict betweenness per candidate
  always_ff @(posedge clk) begin
    if (adv.s5) begin
      a_btw <= (d_ab4 < d_bc4) && (d_ac4 < d_bc4);
      b_btw <= (d_ab4 < d_ac4) && (d_bc4 < d_ac4);
      c_btw <= (d_ac4 < d_ab4) && (d_bc4 < d_ab4);
    end
  end

  // cross product magnitude, stages 2 to 5
  ctpc_cross_mag #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk (clk),
    .adv (adv),
    .u   (u),
    .v   (v),
    .mag (mag)
  );

  // verdict select, candidates in order a, b, c
  always_comb begin
    if (TOL_BITS'(mag) > tolerance) begin
      verdict_next = VERDICT_NOT_COLLINEAR;
    end else if (a_btw) begin
      verdict_next = VERDICT_A_BETWEEN;
    end else if (b_btw) begin
      verdict_next = VERDICT_B_BETWEEN;
    end else if (c_btw) begin
      verdict_next = VERDICT_C_BETWEEN;
    end else begin
      verdict_next = VERDICT_NONE_BETWEEN;
    end
  end

  // stage 6: output register
  always_ff @(posedge clk) begin
    if (adv.s6) begin
      verdict_r <= verdict_next;
    end
  end

  assign verdict = verdict_r;

endmodule

`default_nettype wire
